>>> hw/rtl/mde_pkg.sv
// ---------------------------------------------------------------------------
// mde_pkg
// opcode and funct codes, operation kinds and the queue entry format shared
// by the decode and execute halves of the unit
// ---------------------------------------------------------------------------
package mde_pkg;

    localparam int unsigned XLEN  = 32;
    localparam int unsigned REG_W = 5;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTI    = 6'h0a;
    localparam logic [5:0] OPC_SLTIU   = 6'h0b;
    localparam logic [5:0] OPC_ANDI    = 6'h0c;
    localparam logic [5:0] OPC_ORI     = 6'h0d;
    localparam logic [5:0] OPC_LUI     = 6'h0f;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_SW      = 6'h2b;

    // funct codes of the special opcode
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [REG_W-1:0] REG_LINK = 5'd31;
    localparam logic [REG_W-1:0] REG_ZERO = 5'd0;

    typedef enum logic [4:0] {
        K_ADD,
        K_SUB,
        K_AND,
        K_OR,
        K_NOR,
        K_SLT,
        K_SLTU,
        K_SLL,
        K_SRL,
        K_LUI,
        K_LW,
        K_SW,
        K_BEQ,
        K_BNE,
        K_J,
        K_JAL,
        K_JR,
        K_ILLEGAL
    } t_op_kind;

    // one classified instruction waiting for the execute half
    typedef struct packed {
        t_op_kind         kind;
        logic [XLEN-1:0]  opa;      // rs value
        logic [XLEN-1:0]  opb;      // rt value or extended immediate
        logic [XLEN-1:0]  rt_val;   // rt value, kept for stores and branches
        logic [XLEN-1:0]  pc;
        logic [15:0]      imm;
        logic [25:0]      jidx;
        logic [REG_W-1:0] shamt;
        logic [REG_W-1:0] dest;
        logic             wr;
    } t_q_entry;

endpackage

>>> hw/rtl/mde_channels.sv
// ---------------------------------------------------------------------------
// mde channels
// valid/ready channels carrying instruction beats in and result beats out
// ---------------------------------------------------------------------------
interface mde_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic [31:0] instruction_pc;
    logic [31:0] source_value;
    logic [31:0] target_value;

    modport source (
        output valid, instruction_word, instruction_pc, source_value, target_value,
        input  ready
    );
    modport sink (
        input  valid, instruction_word, instruction_pc, source_value, target_value,
        output ready
    );
endinterface

interface mde_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        redirect;
    logic [31:0] next_pc;
    logic        illegal;

    modport source (
        output valid, result_value, dest_reg, reg_write, mem_read, mem_write,
               mem_address, store_data, redirect, next_pc, illegal,
        input  ready
    );
    modport sink (
        input  valid, result_value, dest_reg, reg_write, mem_read, mem_write,
               mem_address, store_data, redirect, next_pc, illegal,
        output ready
    );
endinterface

>>> hw/rtl/mde_decode.sv
// ---------------------------------------------------------------------------
// mde_decode
// front half: classifies an instruction beat and selects its operands
// ---------------------------------------------------------------------------
module mde_decode import mde_pkg::*; (
    mde_in_if.sink     i_in,
    input  logic       i_push_ready,
    output logic       o_push_valid,
    output t_q_entry   o_entry
);

    logic [5:0]      opc;
    logic [5:0]      fn;
    logic [XLEN-1:0] simm;
    logic [XLEN-1:0] zimm;

    assign opc  = i_in.instruction_word[31:26];
    assign fn   = i_in.instruction_word[5:0];
    assign simm = {{16{i_in.instruction_word[15]}}, i_in.instruction_word[15:0]};
    assign zimm = {16'h0000, i_in.instruction_word[15:0]};

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    always_comb begin
        o_entry        = '0;
        o_entry.opa    = i_in.source_value;
        o_entry.opb    = i_in.target_value;
        o_entry.rt_val = i_in.target_value;
        o_entry.pc     = i_in.instruction_pc;
        o_entry.imm    = i_in.instruction_word[15:0];
        o_entry.jidx   = i_in.instruction_word[25:0];
        o_entry.shamt  = i_in.instruction_word[10:6];
        o_entry.kind   = K_ILLEGAL;
        o_entry.wr     = 1'b0;
        o_entry.dest   = REG_ZERO;

        if (opc == OPC_SPECIAL) begin
            o_entry.wr   = 1'b1;
            o_entry.dest = i_in.instruction_word[15:11];
            unique case (fn)
                FN_ADD, FN_ADDU: o_entry.kind = K_ADD;
                FN_SUB, FN_SUBU: o_entry.kind = K_SUB;
                FN_AND:          o_entry.kind = K_AND;
                FN_OR:           o_entry.kind = K_OR;
                FN_NOR:          o_entry.kind = K_NOR;
                FN_SLT:          o_entry.kind = K_SLT;
                FN_SLTU:         o_entry.kind = K_SLTU;
                FN_SLL:          o_entry.kind = K_SLL;
                FN_SRL:          o_entry.kind = K_SRL;
                FN_JR:           o_entry.kind = K_JR;
                default:         o_entry.kind = K_ILLEGAL;
            endcase
            if (o_entry.kind == K_JR || o_entry.kind == K_ILLEGAL) begin
                o_entry.wr   = 1'b0;
                o_entry.dest = REG_ZERO;
            end
        end else begin
            // immediate formats write rt
            o_entry.dest = i_in.instruction_word[20:16];
            o_entry.opb  = simm;
            unique case (opc)
                OPC_J:               o_entry.kind = K_J;
                OPC_JAL:             o_entry.kind = K_JAL;
                OPC_BEQ:             o_entry.kind = K_BEQ;
                OPC_BNE:             o_entry.kind = K_BNE;
                OPC_ADDI, OPC_ADDIU: o_entry.kind = K_ADD;
                OPC_SLTI:            o_entry.kind = K_SLT;
                OPC_SLTIU:           o_entry.kind = K_SLTU;
                OPC_ANDI:            o_entry.kind = K_AND;
                OPC_ORI:             o_entry.kind = K_OR;
                OPC_LUI:             o_entry.kind = K_LUI;
                OPC_LW:              o_entry.kind = K_LW;
                OPC_SW:              o_entry.kind = K_SW;
                default:             o_entry.kind = K_ILLEGAL;
            endcase
            if (opc == OPC_ANDI || opc == OPC_ORI) begin
                o_entry.opb = zimm;
            end
            unique case (o_entry.kind)
                K_ADD, K_SLT, K_SLTU, K_AND, K_OR, K_LUI, K_LW: begin
                    o_entry.wr = 1'b1;
                end
                K_JAL: begin
                    o_entry.wr   = 1'b1;
                    o_entry.dest = REG_LINK;
                end
                default: begin
                    o_entry.wr   = 1'b0;
                    o_entry.dest = REG_ZERO;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/mde_queue.sv
// ---------------------------------------------------------------------------
// mde_queue
// short first-in first-out queue of classified instructions
// ---------------------------------------------------------------------------
module mde_queue import mde_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    output logic     o_push_ready,
    input  t_q_entry i_push_entry,
    output logic     o_pop_valid,
    input  logic     i_pop,
    output t_q_entry o_pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

>>> hw/rtl/mde_execute.sv
// ---------------------------------------------------------------------------
// mde_execute
// back half: carries out one queued instruction into the result register
// ---------------------------------------------------------------------------
module mde_execute import mde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_q_entry   i_q_entry,
    output logic       o_pop,
    mde_out_if.source  o_out
);

    logic [XLEN-1:0] pc4;
    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] simm;
    logic [XLEN-1:0] br_target;
    logic [XLEN-1:0] jmp_target;

    logic [XLEN-1:0]  n_res, n_addr, n_sdata, n_npc;
    logic [REG_W-1:0] n_dest;
    logic             n_wr, n_mrd, n_mwr, n_redir, n_bad;

    logic             r_valid;
    logic [XLEN-1:0]  r_res, r_addr, r_sdata, r_npc;
    logic [REG_W-1:0] r_dest;
    logic             r_wr, r_mrd, r_mwr, r_redir, r_bad;

    // result register frees up when empty or being drained this cycle
    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    assign pc4        = i_q_entry.pc + 32'd4;
    assign sum        = i_q_entry.opa + i_q_entry.opb;
    assign simm       = {{16{i_q_entry.imm[15]}}, i_q_entry.imm};
    assign br_target  = pc4 + {simm[29:0], 2'b00};
    assign jmp_target = {pc4[31:28], i_q_entry.jidx, 2'b00};

    always_comb begin
        n_res   = '0;
        n_addr  = '0;
        n_sdata = '0;
        n_npc   = pc4;
        n_dest  = i_q_entry.dest;
        n_wr    = i_q_entry.wr;
        n_mrd   = 1'b0;
        n_mwr   = 1'b0;
        n_redir = 1'b0;
        n_bad   = 1'b0;
        unique case (i_q_entry.kind)
            K_ADD:  n_res = sum;
            K_SUB:  n_res = i_q_entry.opa - i_q_entry.opb;
            K_AND:  n_res = i_q_entry.opa & i_q_entry.opb;
            K_OR:   n_res = i_q_entry.opa | i_q_entry.opb;
            K_NOR:  n_res = ~(i_q_entry.opa | i_q_entry.opb);
            K_SLT:  n_res = XLEN'($signed(i_q_entry.opa) < $signed(i_q_entry.opb));
            K_SLTU: n_res = XLEN'(i_q_entry.opa < i_q_entry.opb);
            K_SLL:  n_res = i_q_entry.opb << i_q_entry.shamt;
            K_SRL:  n_res = i_q_entry.opb >> i_q_entry.shamt;
            K_LUI:  n_res = {i_q_entry.imm, 16'h0000};
            K_LW: begin
                n_mrd  = 1'b1;
                n_addr = sum;
                n_res  = sum;
            end
            K_SW: begin
                n_mwr   = 1'b1;
                n_addr  = sum;
                n_sdata = i_q_entry.rt_val;
            end
            K_BEQ: begin
                if (i_q_entry.opa == i_q_entry.rt_val) begin
                    n_redir = 1'b1;
                    n_npc   = br_target;
                end
            end
            K_BNE: begin
                if (i_q_entry.opa != i_q_entry.rt_val) begin
                    n_redir = 1'b1;
                    n_npc   = br_target;
                end
            end
            K_J: begin
                n_redir = 1'b1;
                n_npc   = jmp_target;
            end
            K_JAL: begin
                n_redir = 1'b1;
                n_npc   = jmp_target;
                n_res   = pc4 + 32'd4;
            end
            K_JR: begin
                n_redir = 1'b1;
                n_npc   = i_q_entry.opa;
            end
            default: begin
                n_bad  = 1'b1;
                n_wr   = 1'b0;
                n_dest = REG_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res   <= n_res;
            r_addr  <= n_addr;
            r_sdata <= n_sdata;
            r_npc   <= n_npc;
            r_dest  <= n_dest;
            r_wr    <= n_wr;
            r_mrd   <= n_mrd;
            r_mwr   <= n_mwr;
            r_redir <= n_redir;
            r_bad   <= n_bad;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.result_value = r_res;
    assign o_out.dest_reg     = r_dest;
    assign o_out.reg_write    = r_wr;
    assign o_out.mem_read     = r_mrd;
    assign o_out.mem_write    = r_mwr;
    assign o_out.mem_address  = r_addr;
    assign o_out.store_data   = r_sdata;
    assign o_out.redirect     = r_redir;
    assign o_out.next_pc      = r_npc;
    assign o_out.illegal      = r_bad;

endmodule

>>> hw/rtl/mips_decode_execute_unit.sv
// ---------------------------------------------------------------------------
// mips_decode_execute_unit
// decode and execute of a mips32 integer subset, one instruction per clock
// ---------------------------------------------------------------------------
// usage
//   i_in carries one beat per instruction: the word, its pc and the values
//   of the registers named by rs and rt
//   o_out carries one result beat per instruction: alu or link value,
//   destination and write flag, lw/sw request, redirect with next pc, and
//   an illegal flag that suppresses every write
//   an instruction beat is decoded and classified in the front half, written
//   into a short queue, then executed by the back half into a result
//   register
//   throughput is one instruction per clock while the receiver is ready:
//   the result register reloads in the same cycle it is drained
//   when the receiver stalls the result register holds and the queue soaks
//   up further beats; i_in.ready drops only once the queue is full
//   reset clears the queue pointers and the result valid flag; no result
//   beat is offered until an instruction is accepted
// ---------------------------------------------------------------------------
module mips_decode_execute_unit import mde_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mde_in_if.sink    i_in,
    mde_out_if.source o_out
);

    // front to queue
    logic     push_valid;
    logic     push_ready;
    t_q_entry push_entry;

    // queue to back
    logic     q_valid;
    logic     q_pop;
    t_q_entry q_entry;

    // front half: field extraction, operation kind, operand select
    mde_decode u_decode (
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_entry      (push_entry)
    );

    // decouples decode from a stalled result channel
    mde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_entry  (q_entry)
    );

    // back half: alu, address and branch target adders, result register
    mde_execute u_execute (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

`ifndef SYNTH
    // an illegal instruction writes nothing and does not redirect
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.illegal |->
            !o_out.reg_write && !o_out.mem_read && !o_out.mem_write && !o_out.redirect)
        else $error("illegal result carries a write or redirect");

    // a load writes its destination and reports the address as its result
    a_load_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.mem_read |->
            o_out.reg_write && !o_out.mem_write && o_out.result_value == o_out.mem_address)
        else $error("load result malformed");

    // no destination is named when nothing is written
    a_dest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.reg_write |-> o_out.dest_reg == REG_ZERO)
        else $error("destination set without a register write");

    // an empty result register always takes the head of the queue
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && !o_out.valid |-> q_pop)
        else $error("back half idle while the queue holds work");
`endif

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for mips_decode_execute_unit: instruction beats go in
// with random gaps, result beats are drained with random stalls, and every
// result is compared field by field with an in-bench decode/execute
// prediction kept in order in a small scoreboard
// ---------------------------------------------------------------------------
module tb_top;
    import mde_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;  // cycles with no beat moving
    localparam int unsigned HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned DRAIN_TAIL  = 10;    // settle cycles after last result

    // codes that the unit does not implement
    localparam logic [5:0] OPC_UNUSED = 6'h3f;
    localparam logic [5:0] FN_UNUSED  = 6'h01;

    // one result beat as seen on o_out
    typedef struct packed {
        logic [31:0] result_value;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        redirect;
        logic [31:0] next_pc;
        logic        illegal;
    } t_exec_result;

    // in-order store of predicted results, filled on input beats and
    // consumed on output beats
    class exec_scoreboard;
        t_exec_result pending_results[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
        endfunction

        // decode and execute one instruction
        function t_exec_result predict_outcome(input logic [31:0] word,
                                               input logic [31:0] pc,
                                               input logic [31:0] rs_val,
                                               input logic [31:0] rt_val);
            t_exec_result r;
            logic [5:0]   opc;
            logic [5:0]   fn;
            logic [4:0]   rt_f;
            logic [4:0]   rd_f;
            logic [4:0]   sh_f;
            logic [31:0]  simm;
            logic [31:0]  zimm;
            logic [31:0]  pc4;
            logic [31:0]  jump_tgt;
            logic [31:0]  branch_tgt;
            opc        = word[31:26];
            rt_f       = word[20:16];
            rd_f       = word[15:11];
            sh_f       = word[10:6];
            fn         = word[5:0];
            simm       = {{16{word[15]}}, word[15:0]};
            zimm       = {16'h0000, word[15:0]};
            pc4        = pc + 32'd4;
            jump_tgt   = {pc4[31:28], word[25:0], 2'b00};
            branch_tgt = pc4 + (simm << 2);
            r          = '0;
            r.next_pc  = pc4;
            if (opc == OPC_SPECIAL) begin
                r.reg_write = 1'b1;
                r.dest_reg  = rd_f;
                case (fn)
                    FN_ADD, FN_ADDU: r.result_value = rs_val + rt_val;
                    FN_SUB, FN_SUBU: r.result_value = rs_val - rt_val;
                    FN_AND:  r.result_value = rs_val & rt_val;
                    FN_OR:   r.result_value = rs_val | rt_val;
                    FN_NOR:  r.result_value = ~(rs_val | rt_val);
                    FN_SLT:  r.result_value = {31'b0, $signed(rs_val) < $signed(rt_val)};
                    FN_SLTU: r.result_value = {31'b0, rs_val < rt_val};
                    FN_SLL:  r.result_value = rt_val << sh_f;
                    FN_SRL:  r.result_value = rt_val >> sh_f;
                    FN_JR: begin
                        r.reg_write = 1'b0;
                        r.dest_reg  = REG_ZERO;
                        r.redirect  = 1'b1;
                        r.next_pc   = rs_val;
                    end
                    default: begin
                        r.reg_write = 1'b0;
                        r.dest_reg  = REG_ZERO;
                        r.illegal   = 1'b1;
                    end
                endcase
            end else begin
                case (opc)
                    OPC_J: begin
                        r.redirect = 1'b1;
                        r.next_pc  = jump_tgt;
                    end
                    OPC_JAL: begin
                        r.redirect     = 1'b1;
                        r.next_pc      = jump_tgt;
                        r.reg_write    = 1'b1;
                        r.dest_reg     = REG_LINK;
                        r.result_value = pc + 32'd8;
                    end
                    OPC_BEQ: begin
                        if (rs_val == rt_val) begin
                            r.redirect = 1'b1;
                            r.next_pc  = branch_tgt;
                        end
                    end
                    OPC_BNE: begin
                        if (rs_val != rt_val) begin
                            r.redirect = 1'b1;
                            r.next_pc  = branch_tgt;
                        end
                    end
                    OPC_ADDI, OPC_ADDIU: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.result_value = rs_val + simm;
                    end
                    OPC_SLTI: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.result_value = {31'b0, $signed(rs_val) < $signed(simm)};
                    end
                    OPC_SLTIU: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.result_value = {31'b0, rs_val < simm};
                    end
                    OPC_ANDI: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.result_value = rs_val & zimm;
                    end
                    OPC_ORI: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.result_value = rs_val | zimm;
                    end
                    OPC_LUI: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.result_value = {word[15:0], 16'h0000};
                    end
                    OPC_LW: begin
                        r.reg_write    = 1'b1;
                        r.dest_reg     = rt_f;
                        r.mem_read     = 1'b1;
                        r.mem_address  = rs_val + simm;
                        r.result_value = rs_val + simm;
                    end
                    OPC_SW: begin
                        r.mem_write   = 1'b1;
                        r.mem_address = rs_val + simm;
                        r.store_data  = rt_val;
                    end
                    default: r.illegal = 1'b1;
                endcase
            end
            return r;
        endfunction

        function void note_instruction(input logic [31:0] word, input logic [31:0] pc,
                                       input logic [31:0] rs_val, input logic [31:0] rt_val);
            pending_results.push_back(predict_outcome(word, pc, rs_val, rt_val));
        endfunction

        function void compare_field(input string fld, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t  %s mismatch: expected %h, actual %h", $time, fld, want, got);
            end
        endfunction

        function void check_result(input t_exec_result got);
            t_exec_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t  result beat with nothing expected: expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_value", want.result_value, got.result_value);
            compare_field("dest_reg",     32'(want.dest_reg),  32'(got.dest_reg));
            compare_field("reg_write",    32'(want.reg_write), 32'(got.reg_write));
            compare_field("mem_read",     32'(want.mem_read),  32'(got.mem_read));
            compare_field("mem_write",    32'(want.mem_write), 32'(got.mem_write));
            compare_field("mem_address",  want.mem_address,  got.mem_address);
            compare_field("store_data",   want.store_data,   got.store_data);
            compare_field("redirect",     32'(want.redirect),  32'(got.redirect));
            compare_field("next_pc",      want.next_pc,      got.next_pc);
            compare_field("illegal",      32'(want.illegal),   32'(got.illegal));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    // idling controls, set per phase by the stimulus process
    bit in_idle_en;
    bit out_idle_en;
    bit hold_req;     // asks the receiver for one long hold-off

    int unsigned    stall_cycles;
    exec_scoreboard sb;

    mde_in_if  in_ch ();
    mde_out_if out_ch ();

    mips_decode_execute_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // instruction encoders
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs_f,
                                          input logic [4:0] rt_f, input logic [4:0] rd_f,
                                          input logic [4:0] sh_f);
        return {OPC_SPECIAL, rs_f, rt_f, rd_f, sh_f, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs_f,
                                          input logic [4:0] rt_f, input logic [15:0] imm);
        return {opc, rs_f, rt_f, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] opc, input logic [25:0] idx);
        return {opc, idx};
    endfunction

    // operand and pc values, biased towards the corners of the 32-bit range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return 32'h0fff_fffc;   // pc+4 crosses a jump region
            5:       return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // mostly legal instructions with random fields, some noise
    function automatic logic [31:0] random_instr();
        logic [4:0]  rs_f;
        logic [4:0]  rt_f;
        logic [4:0]  rd_f;
        logic [4:0]  sh_f;
        logic [5:0]  code;
        int unsigned pick;
        rs_f = 5'($urandom);
        rt_f = 5'($urandom);
        rd_f = 5'($urandom);
        sh_f = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            case ($urandom_range(0, 11))
                0:       code = FN_ADD;
                1:       code = FN_ADDU;
                2:       code = FN_SUB;
                3:       code = FN_SUBU;
                4:       code = FN_AND;
                5:       code = FN_OR;
                6:       code = FN_NOR;
                7:       code = FN_SLT;
                8:       code = FN_SLTU;
                9:       code = FN_SLL;
                10:      code = FN_SRL;
                default: code = FN_JR;
            endcase
            return enc_r(code, rs_f, rt_f, rd_f, sh_f);
        end else if (pick < 92) begin
            case ($urandom_range(0, 12))
                0:       code = OPC_J;
                1:       code = OPC_JAL;
                2:       code = OPC_BEQ;
                3:       code = OPC_BNE;
                4:       code = OPC_ADDI;
                5:       code = OPC_ADDIU;
                6:       code = OPC_SLTI;
                7:       code = OPC_SLTIU;
                8:       code = OPC_ANDI;
                9:       code = OPC_ORI;
                10:      code = OPC_LUI;
                11:      code = OPC_LW;
                default: code = OPC_SW;
            endcase
            if (code == OPC_J || code == OPC_JAL)
                return enc_j(code, 26'($urandom));
            return enc_i(code, rs_f, rt_f, 16'($urandom));
        end else if (pick < 96) begin
            // special opcode with any funct, mostly unsupported ones
            code = 6'($urandom);
            return enc_r(code, rs_f, rt_f, rd_f, sh_f);
        end
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // sender: optional gap, then offer the beat until it is taken
    // ------------------------------------------------------------------
    task automatic send_instr(input logic [31:0] word, input logic [31:0] pc,
                              input logic [31:0] rs_val, input logic [31:0] rt_val);
        int unsigned gap;
        gap = in_idle_en ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.instruction_word = word;
        in_ch.instruction_pc   = pc;
        in_ch.source_value     = rs_val;
        in_ch.target_value     = rt_val;
        in_ch.valid            = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_instruction(word, pc, rs_val, rt_val);
        @(negedge clk);
    endtask

    // stop offering and wait until every predicted result has been seen
    task automatic wait_all_results();
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned  gap;
        t_exec_result got;
        out_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n)
            @(negedge clk);
        forever begin
            if (hold_req) begin
                // hold off long enough for the queue to fill and i_in to stall
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = out_idle_en ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.result_value = out_ch.result_value;
            got.dest_reg     = out_ch.dest_reg;
            got.reg_write    = out_ch.reg_write;
            got.mem_read     = out_ch.mem_read;
            got.mem_write    = out_ch.mem_write;
            got.mem_address  = out_ch.mem_address;
            got.store_data   = out_ch.store_data;
            got.redirect     = out_ch.redirect;
            got.next_pc      = out_ch.next_pc;
            got.illegal      = out_ch.illegal;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when no beat moves on either side for too long
    // ------------------------------------------------------------------
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] word;
        logic [31:0] rs_val;
        logic [31:0] rt_val;
        sb = new();
        rst_n                  = 1'b0;
        in_idle_en             = 1'b1;
        out_idle_en            = 1'b1;
        hold_req               = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.instruction_word = '0;
        in_ch.instruction_pc   = '0;
        in_ch.source_value     = '0;
        in_ch.target_value     = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        // add wraps, shamt set on a non-shift op must be ignored
        send_instr(enc_r(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd7), 32'h0000_1000,
                   32'hffff_ffff, 32'h0000_0001);
        send_instr(enc_r(FN_ADDU, 5'd31, 5'd31, 5'd31, 5'd0), 32'hffff_fffc,
                   32'h7fff_ffff, 32'h0000_0001);
        send_instr(enc_r(FN_SUB, 5'd0, 5'd0, 5'd5, 5'd31), 32'h0, 32'h0, 32'h1);
        send_instr(enc_r(FN_SUBU, 5'd3, 5'd4, 5'd6, 5'd0), 32'h4,
                   32'h8000_0000, 32'h0000_0001);
        send_instr(enc_r(FN_AND, 5'd1, 5'd2, 5'd7, 5'd0), 32'h8, 32'hffff_ffff, 32'ha5a5_5a5a);
        send_instr(enc_r(FN_OR, 5'd1, 5'd2, 5'd8, 5'd0), 32'hc, 32'h0f0f_0000, 32'h0000_f0f0);
        send_instr(enc_r(FN_NOR, 5'd1, 5'd2, 5'd9, 5'd0), 32'h10, 32'h0, 32'h0);
        // signed against unsigned compare of the same operands
        send_instr(enc_r(FN_SLT, 5'd1, 5'd2, 5'd10, 5'd0), 32'h14,
                   32'h8000_0000, 32'h0000_0001);
        send_instr(enc_r(FN_SLTU, 5'd1, 5'd2, 5'd11, 5'd0), 32'h18,
                   32'h8000_0000, 32'h0000_0001);
        // shift by 31, sll into register zero, srl is logical
        send_instr(enc_r(FN_SLL, 5'd0, 5'd2, 5'd0, 5'd31), 32'h1c, 32'h0, 32'h0000_0001);
        send_instr(enc_r(FN_SRL, 5'd0, 5'd2, 5'd12, 5'd31), 32'h20, 32'h0, 32'h8000_0000);
        // jr with junk in rt, rd and shamt
        send_instr(enc_r(FN_JR, 5'd4, 5'd31, 5'd31, 5'd31), 32'h24,
                   32'hdead_beef, 32'hffff_ffff);
        send_instr(enc_r(FN_UNUSED, 5'd1, 5'd2, 5'd3, 5'd4), 32'hffff_fffc,
                   32'hffff_ffff, 32'hffff_ffff);
        send_instr(enc_i(OPC_ADDI, 5'd1, 5'd2, 16'h8000), 32'h28, 32'h0, 32'h0);
        send_instr(enc_i(OPC_ADDIU, 5'd1, 5'd3, 16'h7fff), 32'h2c, 32'h7fff_ffff, 32'h0);
        send_instr(enc_i(OPC_SLTI, 5'd1, 5'd4, 16'h0000), 32'h30, 32'hffff_ffff, 32'h0);
        // sltiu compares against the sign-extended immediate
        send_instr(enc_i(OPC_SLTIU, 5'd1, 5'd5, 16'hffff), 32'h34, 32'h1, 32'h0);
        send_instr(enc_i(OPC_ANDI, 5'd1, 5'd6, 16'h8000), 32'h38, 32'hffff_ffff, 32'h0);
        send_instr(enc_i(OPC_ORI, 5'd1, 5'd7, 16'hffff), 32'h3c, 32'h0, 32'h0);
        send_instr(enc_i(OPC_LUI, 5'd1, 5'd31, 16'hffff), 32'h40, 32'h1234_5678, 32'h0);
        // load into register zero with a negative offset
        send_instr(enc_i(OPC_LW, 5'd1, 5'd0, 16'h8000), 32'h44, 32'h0, 32'hffff_ffff);
        send_instr(enc_i(OPC_SW, 5'd1, 5'd2, 16'h0004), 32'h48, 32'hffff_fffc, 32'h1234_5678);
        // taken branch wrapping below zero, branch not taken
        send_instr(enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0, 32'h5, 32'h5);
        send_instr(enc_i(OPC_BNE, 5'd1, 5'd2, 16'h7fff), 32'h4c, 32'h5, 32'h5);
        // jump region taken from pc+4, which wraps at the top
        send_instr(enc_j(OPC_J, 26'h3ff_ffff), 32'hffff_fffc, 32'h0, 32'h0);
        send_instr(enc_j(OPC_JAL, 26'h000_0000), 32'hefff_fffc, 32'h0, 32'h0);
        send_instr(enc_i(OPC_UNUSED, 5'd31, 5'd31, 16'hffff), 32'h50,
                   32'hffff_ffff, 32'hffff_ffff);

        // random phases with different idling on each side
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1, 5: begin in_idle_en = 1'b0; out_idle_en = 1'b0; end
                2: begin
                    // receiver holds off while the sender keeps offering
                    in_idle_en  = 1'b0;
                    out_idle_en = 1'b1;
                    hold_req    = 1'b1;
                end
                3:       begin in_idle_en = 1'b1; out_idle_en = 1'b0; end
                default: begin in_idle_en = 1'b1; out_idle_en = 1'b1; end
            endcase
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                word   = random_instr();
                rs_val = pick_value();
                rt_val = pick_value();
                // make half the branches see equal operands
                if ((word[31:26] == OPC_BEQ || word[31:26] == OPC_BNE) && $urandom_range(0, 1))
                    rt_val = rs_val;
                send_instr(word, pick_value(), rs_val, rt_val);
            end
            // after phase 3 the sender pauses until the unit is empty
            if (phase == 3)
                wait_all_results();
        end

        out_idle_en = 1'b0;
        wait_all_results();
        repeat (DRAIN_TAIL) @(negedge clk);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
